// ----- hdl/sid_pkg.sv -----
// ----------------------------------------------------------------------------
// sid_pkg: segment intersection shared definitions
// Widths, status codes, pipeline metadata and the divider step.
// ----------------------------------------------------------------------------
package sid_pkg;

  // coordinate and fixed-point widths
  localparam int CW        = 16;
  localparam int FRAC_BITS = 8;
  localparam int OW        = 24;

  // derived arithmetic widths
  localparam int DW         = CW + 1;            // coordinate difference
  localparam int PW         = 2 * DW;            // one product term
  localparam int XW         = PW + 1;            // cross product
  localparam int QW         = DW + FRAC_BITS;    // quotient magnitude
  localparam int NW         = DW + XW + FRAC_BITS; // scaled numerator
  localparam int SW         = OW + 2;            // final sum before clamp
  localparam int DIV_STAGES = QW;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_SHARED   = 2'd2,
    ST_CROSS    = 2'd3
  } status_e;

  // data that rides along with each item
  typedef struct packed {
    status_e              status;
    logic signed [CW-1:0] base_x;
    logic signed [CW-1:0] base_y;
    logic                 neg_x;
    logic                 neg_y;
  } meta_t;

  // one restoring step: word holds {remainder, numerator tail / quotient}
  function automatic logic [NW-1:0] div_step(input logic [NW-1:0] w,
                                             input logic [XW-1:0] d);
    logic [XW:0]   t;
    logic [XW:0]   s;
    logic          ge;
    logic [XW-1:0] r;
    t  = w[NW-1:QW-1];
    s  = t - {1'b0, d};
    ge = (t >= {1'b0, d});
    r  = ge ? s[XW-1:0] : t[XW-1:0];
    return {r, w[QW-2:0], ge};
  endfunction

endpackage

// ----- hdl/sid_seg_if.sv -----
// ----------------------------------------------------------------------------
// sid_seg_if: segment pair channel
// Valid/ready channel carrying the two segments of one item.
// ----------------------------------------------------------------------------
interface sid_seg_if;
  logic        valid;
  logic        ready;
  logic [15:0] first_start_x;
  logic [15:0] first_start_y;
  logic [15:0] first_end_x;
  logic [15:0] first_end_y;
  logic [15:0] second_start_x;
  logic [15:0] second_start_y;
  logic [15:0] second_end_x;
  logic [15:0] second_end_y;

  modport source (output valid, first_start_x, first_start_y, first_end_x, first_end_y,
                  second_start_x, second_start_y, second_end_x, second_end_y,
                  input ready);
  modport sink (input valid, first_start_x, first_start_y, first_end_x, first_end_y,
                second_start_x, second_start_y, second_end_x, second_end_y,
                output ready);
endinterface

// ----- hdl/sid_res_if.sv -----
// ----------------------------------------------------------------------------
// sid_res_if: intersection result channel
// Valid/ready channel carrying status and crossing point.
// ----------------------------------------------------------------------------
interface sid_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cross_status;
  logic [23:0] cross_x;
  logic [23:0] cross_y;

  modport source (output valid, cross_status, cross_x, cross_y, input ready);
  modport sink (input valid, cross_status, cross_x, cross_y, output ready);
endinterface

// ----- hdl/sid_geom.sv -----
// ----------------------------------------------------------------------------
// sid_geom: segment geometry front end
// Input register, differences, products, cross products with classification,
// magnitudes and signs, scaled numerators, one register stage each.
// ----------------------------------------------------------------------------
module sid_geom (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  logic                             valid_i,
  input  logic signed [sid_pkg::CW-1:0]    s1x_i,
  input  logic signed [sid_pkg::CW-1:0]    s1y_i,
  input  logic signed [sid_pkg::CW-1:0]    e1x_i,
  input  logic signed [sid_pkg::CW-1:0]    e1y_i,
  input  logic signed [sid_pkg::CW-1:0]    s2x_i,
  input  logic signed [sid_pkg::CW-1:0]    s2y_i,
  input  logic signed [sid_pkg::CW-1:0]    e2x_i,
  input  logic signed [sid_pkg::CW-1:0]    e2y_i,
  output logic                             valid_o,
  output sid_pkg::meta_t                   meta_o,
  output logic [sid_pkg::NW-1:0]           num_x_o,
  output logic [sid_pkg::NW-1:0]           num_y_o,
  output logic [sid_pkg::XW-1:0]           den_o
);
  import sid_pkg::*;

  // stage a: input register
  logic signed [CW-1:0] a_s1x_q, a_s1y_q, a_e1x_q, a_e1y_q;
  logic signed [CW-1:0] a_s2x_q, a_s2y_q, a_e2x_q, a_e2y_q;
  logic                 a_v_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_s1x_q <= s1x_i; a_s1y_q <= s1y_i; a_e1x_q <= e1x_i; a_e1y_q <= e1y_i;
      a_s2x_q <= s2x_i; a_s2y_q <= s2y_i; a_e2x_q <= e2x_i; a_e2y_q <= e2y_i;
    end
  end

  // stage b: differences and endpoint matches
  logic signed [DW-1:0] b_d1x_d, b_d1y_d, b_d2x_d, b_d2y_d;
  logic signed [DW-1:0] b_ux_d, b_uy_d, b_wx_d, b_wy_d, b_tx_d, b_ty_d, b_gx_d, b_gy_d;
  logic                 ss, se, es, ee;
  meta_t                b_meta_d;

  assign b_d1x_d = {a_e1x_q[CW-1], a_e1x_q} - {a_s1x_q[CW-1], a_s1x_q};
  assign b_d1y_d = {a_e1y_q[CW-1], a_e1y_q} - {a_s1y_q[CW-1], a_s1y_q};
  assign b_d2x_d = {a_e2x_q[CW-1], a_e2x_q} - {a_s2x_q[CW-1], a_s2x_q};
  assign b_d2y_d = {a_e2y_q[CW-1], a_e2y_q} - {a_s2y_q[CW-1], a_s2y_q};
  assign b_ux_d  = {a_s2x_q[CW-1], a_s2x_q} - {a_s1x_q[CW-1], a_s1x_q};
  assign b_uy_d  = {a_s2y_q[CW-1], a_s2y_q} - {a_s1y_q[CW-1], a_s1y_q};
  assign b_wx_d  = {a_e2x_q[CW-1], a_e2x_q} - {a_s1x_q[CW-1], a_s1x_q};
  assign b_wy_d  = {a_e2y_q[CW-1], a_e2y_q} - {a_s1y_q[CW-1], a_s1y_q};
  assign b_tx_d  = {a_s1x_q[CW-1], a_s1x_q} - {a_s2x_q[CW-1], a_s2x_q};
  assign b_ty_d  = {a_s1y_q[CW-1], a_s1y_q} - {a_s2y_q[CW-1], a_s2y_q};
  assign b_gx_d  = {a_e1x_q[CW-1], a_e1x_q} - {a_s2x_q[CW-1], a_s2x_q};
  assign b_gy_d  = {a_e1y_q[CW-1], a_e1y_q} - {a_s2y_q[CW-1], a_s2y_q};

  assign ss = (a_s1x_q == a_s2x_q) && (a_s1y_q == a_s2y_q);
  assign se = (a_s1x_q == a_e2x_q) && (a_s1y_q == a_e2y_q);
  assign es = (a_e1x_q == a_s2x_q) && (a_e1y_q == a_s2y_q);
  assign ee = (a_e1x_q == a_e2x_q) && (a_e1y_q == a_e2y_q);

  // shared endpoint pick, otherwise second start as the crossing base
  always_comb begin
    b_meta_d        = '0;
    b_meta_d.status = (ss || se || es || ee) ? ST_SHARED : ST_CROSS;
    b_meta_d.base_x = a_s2x_q;
    b_meta_d.base_y = a_s2y_q;
    if (ee) begin
      b_meta_d.base_x = a_e2x_q;
      b_meta_d.base_y = a_e2y_q;
    end else if (!es && se) begin
      b_meta_d.base_x = a_s1x_q;
      b_meta_d.base_y = a_s1y_q;
    end
  end

  logic signed [DW-1:0] b_d1x_q, b_d1y_q, b_d2x_q, b_d2y_q;
  logic signed [DW-1:0] b_ux_q, b_uy_q, b_wx_q, b_wy_q, b_tx_q, b_ty_q, b_gx_q, b_gy_q;
  meta_t                b_meta_q;
  logic                 b_v_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b_d1x_q <= b_d1x_d; b_d1y_q <= b_d1y_d; b_d2x_q <= b_d2x_d; b_d2y_q <= b_d2y_d;
      b_ux_q  <= b_ux_d;  b_uy_q  <= b_uy_d;  b_wx_q  <= b_wx_d;  b_wy_q  <= b_wy_d;
      b_tx_q  <= b_tx_d;  b_ty_q  <= b_ty_d;  b_gx_q  <= b_gx_d;  b_gy_q  <= b_gy_d;
      b_meta_q <= b_meta_d;
    end
  end

  // stage c: the ten product terms
  logic signed [PW-1:0] c_p_q [10];
  logic signed [DW-1:0] c_d2x_q, c_d2y_q;
  meta_t                c_meta_q;
  logic                 c_v_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      c_p_q[0] <= b_d1x_q * b_d2y_q;
      c_p_q[1] <= b_d1y_q * b_d2x_q;
      c_p_q[2] <= b_d1x_q * b_uy_q;
      c_p_q[3] <= b_d1y_q * b_ux_q;
      c_p_q[4] <= b_d1x_q * b_wy_q;
      c_p_q[5] <= b_d1y_q * b_wx_q;
      c_p_q[6] <= b_d2x_q * b_ty_q;
      c_p_q[7] <= b_d2y_q * b_tx_q;
      c_p_q[8] <= b_d2x_q * b_gy_q;
      c_p_q[9] <= b_d2y_q * b_gx_q;
      c_d2x_q  <= b_d2x_q;
      c_d2y_q  <= b_d2y_q;
      c_meta_q <= b_meta_q;
    end
  end

  // stage d: cross products and classification
  logic signed [XW-1:0] d_cr [5];
  meta_t                d_meta_d;
  logic                 side1, side2;

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      d_cr[k] = {c_p_q[2*k][PW-1], c_p_q[2*k]} - {c_p_q[2*k+1][PW-1], c_p_q[2*k+1]};
    end
  end

  // strictly same side: both nonzero with equal sign
  assign side1 = (d_cr[1] != '0) && (d_cr[2] != '0) && (d_cr[1][XW-1] == d_cr[2][XW-1]);
  assign side2 = (d_cr[3] != '0) && (d_cr[4] != '0) && (d_cr[3][XW-1] == d_cr[4][XW-1]);

  always_comb begin
    d_meta_d = c_meta_q;
    if (c_meta_q.status != ST_SHARED) begin
      if (d_cr[0] == '0) begin
        d_meta_d.status = ST_PARALLEL;
        d_meta_d.base_x = '0;
        d_meta_d.base_y = '0;
      end else if (side1 || side2) begin
        d_meta_d.status = ST_NONE;
        d_meta_d.base_x = '0;
        d_meta_d.base_y = '0;
      end
    end
  end

  logic signed [XW-1:0] d_c1_q, d_cp_q;
  logic signed [DW-1:0] d_d2x_q, d_d2y_q;
  meta_t                d_meta_q;
  logic                 d_v_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d_c1_q   <= d_cr[1];
      d_cp_q   <= d_cr[0];
      d_d2x_q  <= c_d2x_q;
      d_d2y_q  <= c_d2y_q;
      d_meta_q <= d_meta_d;
    end
  end

  // stage e: magnitudes and quotient signs; c1 - c2 equals minus the direction cross
  logic [XW-1:0] e_c1m_d, e_denm_d;
  logic          den_neg;
  meta_t         e_meta_d;

  assign e_c1m_d  = d_c1_q[XW-1] ? XW'(-d_c1_q) : XW'(d_c1_q);
  assign e_denm_d = d_cp_q[XW-1] ? XW'(-d_cp_q) : XW'(d_cp_q);
  assign den_neg  = !d_cp_q[XW-1] && (d_cp_q != '0);

  always_comb begin
    e_meta_d       = d_meta_q;
    e_meta_d.neg_x = d_d2x_q[DW-1] ^ d_c1_q[XW-1] ^ den_neg;
    e_meta_d.neg_y = d_d2y_q[DW-1] ^ d_c1_q[XW-1] ^ den_neg;
  end

  logic [XW-1:0] e_c1m_q, e_denm_q;
  logic [DW-1:0] e_dxm_q, e_dym_q;
  meta_t         e_meta_q;
  logic          e_v_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      e_c1m_q  <= e_c1m_d;
      e_denm_q <= e_denm_d;
      e_dxm_q  <= d_d2x_q[DW-1] ? DW'(-d_d2x_q) : DW'(d_d2x_q);
      e_dym_q  <= d_d2y_q[DW-1] ? DW'(-d_d2y_q) : DW'(d_d2y_q);
      e_meta_q <= e_meta_d;
    end
  end

  // stage f: scaled numerators |delta| * |c1| * 2^frac
  logic [NW-1:0] f_nx_q, f_ny_q;
  logic [XW-1:0] f_den_q;
  meta_t         f_meta_q;
  logic          f_v_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      f_nx_q   <= {NW'(e_dxm_q) * NW'(e_c1m_q)} << FRAC_BITS;
      f_ny_q   <= {NW'(e_dym_q) * NW'(e_c1m_q)} << FRAC_BITS;
      f_den_q  <= e_denm_q;
      f_meta_q <= e_meta_q;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0; b_v_q <= 1'b0; c_v_q <= 1'b0;
      d_v_q <= 1'b0; e_v_q <= 1'b0; f_v_q <= 1'b0;
    end else if (adv_i) begin
      a_v_q <= valid_i; b_v_q <= a_v_q; c_v_q <= b_v_q;
      d_v_q <= c_v_q;   e_v_q <= d_v_q; f_v_q <= e_v_q;
    end
  end

  assign valid_o = f_v_q;
  assign meta_o  = f_meta_q;
  assign num_x_o = f_nx_q;
  assign num_y_o = f_ny_q;
  assign den_o   = f_den_q;

  // an accepted beat shows up in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && valid_i) |=> a_v_q)
    else $error("accepted beat missing from first stage");

  // a stalled pipeline keeps its valid pattern
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(f_v_q) && $stable(c_v_q))
    else $error("valid bits moved during stall");

endmodule

// ----- hdl/sid_div.sv -----
// ----------------------------------------------------------------------------
// sid_div: pipelined restoring divider
// One quotient bit per stage for both coordinates against a shared divisor.
// ----------------------------------------------------------------------------
module sid_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    valid_i,
  input  sid_pkg::meta_t          meta_i,
  input  logic [sid_pkg::NW-1:0]  num_x_i,
  input  logic [sid_pkg::NW-1:0]  num_y_i,
  input  logic [sid_pkg::XW-1:0]  den_i,
  output logic                    valid_o,
  output sid_pkg::meta_t          meta_o,
  output logic [sid_pkg::QW-1:0]  quo_x_o,
  output logic [sid_pkg::QW-1:0]  quo_y_o
);
  import sid_pkg::*;

  logic [NW-1:0] wx_q [DIV_STAGES];
  logic [NW-1:0] wy_q [DIV_STAGES];
  logic [XW-1:0] den_q [DIV_STAGES];
  meta_t         meta_q [DIV_STAGES];
  logic          v_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
    logic [NW-1:0] wx_in, wy_in;
    logic [XW-1:0] den_in;
    meta_t         meta_in;
    logic          v_in;

    if (k == 0) begin : g_head
      assign wx_in   = num_x_i;
      assign wy_in   = num_y_i;
      assign den_in  = den_i;
      assign meta_in = meta_i;
      assign v_in    = valid_i;
    end else begin : g_body
      assign wx_in   = wx_q[k-1];
      assign wy_in   = wy_q[k-1];
      assign den_in  = den_q[k-1];
      assign meta_in = meta_q[k-1];
      assign v_in    = v_q[k-1];
    end

    // one shift-compare-subtract per coordinate
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        wx_q[k]   <= div_step(wx_in, den_in);
        wy_q[k]   <= div_step(wy_in, den_in);
        den_q[k]  <= den_in;
        meta_q[k] <= meta_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv_i) begin
        v_q[k] <= v_in;
      end
    end
  end

  assign valid_o = v_q[DIV_STAGES-1];
  assign meta_o  = meta_q[DIV_STAGES-1];
  assign quo_x_o = wx_q[DIV_STAGES-1][QW-1:0];
  assign quo_y_o = wy_q[DIV_STAGES-1][QW-1:0];

endmodule

// ----- hdl/segment_intersection_2d.sv -----
// Pipeline: 32 register stages end to end, from the register that takes a segment
// beat to the output register that holds its result beat.
// Throughput: one pair per cycle unless a full output register is stalled by
// res_o.ready; 6 geometry stages, 25 divider stages (one quotient bit each),
// one output stage. The whole pipeline advances together whenever the output
// register is free. Reset clears all valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
// segment_intersection_2d: 2-D segment intersection
// Classifies two segments and gives the crossing point in fixed point.
// ----------------------------------------------------------------------------
module segment_intersection_2d (
  input  logic clk_i,
  input  logic rst_ni,
  sid_seg_if.sink   seg_i,
  sid_res_if.source res_o
);
  import sid_pkg::*;

  logic          adv;
  logic          g_valid, q_valid;
  meta_t         g_meta, q_meta;
  logic [NW-1:0] g_nx, g_ny;
  logic [XW-1:0] g_den;
  logic [QW-1:0] q_x, q_y;

  // whole pipeline moves when the output register can take a beat
  logic out_v_q;
  assign adv         = !out_v_q || res_o.ready;
  assign seg_i.ready = adv;

  sid_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (seg_i.valid),
    .s1x_i   (seg_i.first_start_x),
    .s1y_i   (seg_i.first_start_y),
    .e1x_i   (seg_i.first_end_x),
    .e1y_i   (seg_i.first_end_y),
    .s2x_i   (seg_i.second_start_x),
    .s2y_i   (seg_i.second_start_y),
    .e2x_i   (seg_i.second_end_x),
    .e2y_i   (seg_i.second_end_y),
    .valid_o (g_valid),
    .meta_o  (g_meta),
    .num_x_o (g_nx),
    .num_y_o (g_ny),
    .den_o   (g_den)
  );

  sid_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (g_valid),
    .meta_i  (g_meta),
    .num_x_i (g_nx),
    .num_y_i (g_ny),
    .den_i   (g_den),
    .valid_o (q_valid),
    .meta_o  (q_meta),
    .quo_x_o (q_x),
    .quo_y_o (q_y)
  );

  // base point scaled plus signed quotient, then clamp
  function automatic logic [OW-1:0] finish(input logic signed [CW-1:0] base,
                                           input logic [QW-1:0] q,
                                           input logic neg, input logic use_q);
    logic signed [SW-1:0] b;
    logic signed [SW-1:0] o;
    logic signed [SW-1:0] s;
    b = SW'(base) <<< FRAC_BITS;
    o = use_q ? (neg ? -SW'(q) : SW'(q)) : '0;
    s = b + o;
    if (s > SW'(2 ** (OW - 1) - 1)) begin
      return {1'b0, {(OW-1){1'b1}}};
    end else if (s < -SW'(2 ** (OW - 1))) begin
      return {1'b1, {(OW-1){1'b0}}};
    end
    return s[OW-1:0];
  endfunction

  logic          use_q;
  status_e       st_q;
  logic [OW-1:0] x_q, y_q;

  assign use_q = (q_meta.status == ST_CROSS);

  // output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q <= q_meta.status;
      x_q  <= finish(q_meta.base_x, q_x, q_meta.neg_x, use_q);
      y_q  <= finish(q_meta.base_y, q_y, q_meta.neg_y, use_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= q_valid;
    end
  end

  assign res_o.valid        = out_v_q;
  assign res_o.cross_status = st_q;
  assign res_o.cross_x      = x_q;
  assign res_o.cross_y      = y_q;

  // no point means zero coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (st_q == ST_NONE || st_q == ST_PARALLEL)) |-> (x_q == '0 && y_q == '0))
    else $error("point given without a crossing");

  // a shared endpoint is an integer point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && st_q == ST_SHARED) |->
      (x_q[FRAC_BITS-1:0] == '0 && y_q[FRAC_BITS-1:0] == '0))
    else $error("shared endpoint has fraction bits");

  // output register only refills while advancing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !adv) |=> (out_v_q && $stable(x_q) && $stable(st_q)))
    else $error("result beat changed while stalled");

endmodule
